// File: hw/rtl/prl_pkg.sv
`timescale 1ns / 1ps
package prl_pkg;
   localparam int REQ_ENTRIES_DEF = 16;
   localparam int BLK_ENTRIES_DEF = 16;
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_CHECK = 2'd1;
   localparam logic [1:0] CMD_REG   = 2'd2;
   localparam logic [1:0] CMD_SIZE  = 2'd3;
   localparam logic [1:0] CSR_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_WINDOW = 2'd1;
   localparam logic [1:0] CSR_BLOCK  = 2'd2;
   localparam logic [1:0] CSR_MAXSZ  = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] source_addr;
      logic        size_ok;
   } job_type;

   typedef struct packed {
      logic        is_blocked;
      logic        newly_blocked;
      logic        size_ok;
      logic        table_full;
      logic [15:0] request_count;
   } rsp_type;
endpackage

// File: hw/rtl/per_source_rate_limiter_blocklist.sv
`timescale 1ns / 1ps
// accept to rsp_valid: S_REQ scans the request table, then S_BLK the block table,
// then S_UPD, S_BUPD and S_OUT, then the result register; S_OUT waits on a stalled result
// the back end takes a new job only in S_IDLE; each scan reads one entry per cycle
// a two-entry queue parts front and back; the result register parts back and rsp side
// reset: synchronous; clears time, table valid bits, queue and registers to defaults
module per_source_rate_limiter_blocklist #(
   parameter int REQ_ENTRIES = prl_pkg::REQ_ENTRIES_DEF,
   parameter int BLK_ENTRIES = prl_pkg::BLK_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_source_addr,
   input  logic [15:0] req_packet_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_blocked,
   output logic        rsp_newly_blocked,
   output logic        rsp_size_ok,
   output logic        rsp_table_full,
   output logic [15:0] rsp_request_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);
   logic [15:0] limit_ff, window_ff, maxsz_ff;
   logic [19:0] block_ff;
   logic job_valid, job_take;
   prl_pkg::job_type job;
   prl_pkg::rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'd100;
         window_ff <= 16'd1;
         block_ff <= 20'd60;
         maxsz_ff <= 16'd1500;
      end else if (csr_write) begin
         case (csr_index)
            prl_pkg::CSR_LIMIT:  limit_ff <= csr_data[15:0];
            prl_pkg::CSR_WINDOW: window_ff <= csr_data[15:0];
            prl_pkg::CSR_BLOCK:  block_ff <= csr_data;
            prl_pkg::CSR_MAXSZ:  maxsz_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   prl_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_source_addr,
      .req_packet_size, .max_packet_size(maxsz_ff),
      .job_valid, .job_take, .job
   );

   prl_back #(.REQ_ENTRIES(REQ_ENTRIES), .BLK_ENTRIES(BLK_ENTRIES)) u_back (
      .clock, .reset, .job_valid, .job_take, .job,
      .request_limit(limit_ff), .window_ticks(window_ff), .block_ticks(block_ff),
      .rsp_valid, .rsp_stall, .rsp
   );

   assign rsp_is_blocked = rsp.is_blocked;
   assign rsp_newly_blocked = rsp.newly_blocked;
   assign rsp_size_ok = rsp.size_ok;
   assign rsp_table_full = rsp.table_full;
   assign rsp_request_count = rsp.request_count;

   a_newly_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newly_blocked |-> rsp_request_count != 16'd0) else $error("newly");
   a_size_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_ok |-> !rsp_is_blocked && rsp_request_count == 16'd0)
      else $error("size");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("hold");
endmodule

// File: hw/rtl/prl_front.sv
`timescale 1ns / 1ps
module prl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_source_addr,
   input  logic [15:0]          req_packet_size,
   input  logic [15:0]          max_packet_size,
   output logic                 job_valid,
   input  logic                 job_take,
   output prl_pkg::job_type     job
);
   prl_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_take;
   assign job = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) begin
         q_ff[wp_ff].cmd <= req_cmd;
         q_ff[wp_ff].source_addr <= req_source_addr;
         q_ff[wp_ff].size_ok <= (req_packet_size <= max_packet_size);
      end
   end
endmodule

// File: hw/rtl/prl_back.sv
`timescale 1ns / 1ps
module prl_back #(
   parameter int REQ_ENTRIES = prl_pkg::REQ_ENTRIES_DEF,
   parameter int BLK_ENTRIES = prl_pkg::BLK_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_take,
   input  prl_pkg::job_type     job,
   input  logic [15:0]          request_limit,
   input  logic [15:0]          window_ticks,
   input  logic [19:0]          block_ticks,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output prl_pkg::rsp_type     rsp
);
   localparam int RW = (REQ_ENTRIES > 1) ? $clog2(REQ_ENTRIES) : 1;
   localparam int BW = (BLK_ENTRIES > 1) ? $clog2(BLK_ENTRIES) : 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_REQ  = 6'b000010,
      S_BLK  = 6'b000100,
      S_UPD  = 6'b001000,
      S_BUPD = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [31:0] now_ff;
   logic [REQ_ENTRIES-1:0] rv_ff;
   logic [BLK_ENTRIES-1:0] bv_ff;
   logic [31:0] rsrc_mem [REQ_ENTRIES];
   logic [15:0] rcnt_mem [REQ_ENTRIES];
   logic [31:0] rst_mem  [REQ_ENTRIES];
   logic [31:0] bsrc_mem [BLK_ENTRIES];
   logic [31:0] bun_mem  [BLK_ENTRIES];

   logic [RW:0] ri_ff;
   logic [BW:0] bi_ff;
   prl_pkg::job_type j_ff;
   logic        rhit_ff, rfree_ff, bhit_ff, bfree_ff;
   logic [RW-1:0] rhi_ff, rfi_ff;
   logic [BW-1:0] bhi_ff, bfi_ff;
   logic [15:0] rc_ff;
   logic        blkd_ff, newly_ff, full_ff;
   logic [15:0] cnt_ff;
   logic        ov_ff;
   logic        out_v_ff;
   prl_pkg::rsp_type out_ff;

   logic [RW-1:0] ri;
   logic [BW-1:0] bi;
   logic [31:0]   rdiff, bdiff;
   logic          rlive, blive;
   logic [15:0]   inc;
   logic          out_free;

   assign ri = ri_ff[RW-1:0];
   assign bi = bi_ff[BW-1:0];
   assign rdiff = now_ff - rst_mem[ri];
   assign rlive = rv_ff[ri] && (rdiff <= {16'd0, window_ticks});
   assign bdiff = bun_mem[bi] - now_ff;
   assign blive = bv_ff[bi] && (bdiff != 32'd0) && !bdiff[31];
   assign inc = (rc_ff == 16'hFFFF) ? rc_ff : rc_ff + 16'd1;
   assign out_free = !out_v_ff || !rsp_stall;

   assign job_take = (st_ff == S_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp = out_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (job_valid) begin
            st_in = S_REQ;
         end
         S_REQ:  if (ri_ff == (RW+1)'(REQ_ENTRIES - 1)) st_in = S_BLK;
         S_BLK:  if (bi_ff == (BW+1)'(BLK_ENTRIES - 1)) st_in = S_UPD;
         S_UPD:  st_in = S_BUPD;
         S_BUPD: st_in = S_OUT;
         S_OUT:  if (out_free) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         now_ff <= '0;
         rv_ff <= '0;
         bv_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if ((st_ff == S_OUT) && out_free) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (job_valid) begin
               j_ff <= job;
               if (job.cmd == prl_pkg::CMD_TICK) now_ff <= now_ff + 32'd1;
               ri_ff <= '0;
               bi_ff <= '0;
               rhit_ff <= 1'b0;
               rfree_ff <= 1'b0;
               bhit_ff <= 1'b0;
               bfree_ff <= 1'b0;
               rhi_ff <= '0;
               rfi_ff <= '0;
               bhi_ff <= '0;
               bfi_ff <= '0;
               rc_ff <= '0;
            end
            S_REQ: begin
               if (!rlive) begin
                  rv_ff[ri] <= 1'b0;
                  if (!rfree_ff) begin
                     rfree_ff <= 1'b1;
                     rfi_ff <= ri;
                  end
               end else if (!rhit_ff && rsrc_mem[ri] == j_ff.source_addr) begin
                  rhit_ff <= 1'b1;
                  rhi_ff <= ri;
                  rc_ff <= rcnt_mem[ri];
               end
               ri_ff <= ri_ff + (RW+1)'(1);
            end
            S_BLK: begin
               if (!blive) begin
                  bv_ff[bi] <= 1'b0;
                  if (!bfree_ff) begin
                     bfree_ff <= 1'b1;
                     bfi_ff <= bi;
                  end
               end else if (!bhit_ff && bsrc_mem[bi] == j_ff.source_addr) begin
                  bhit_ff <= 1'b1;
                  bhi_ff <= bi;
               end
               bi_ff <= bi_ff + (BW+1)'(1);
            end
            S_UPD: begin
               blkd_ff <= bhit_ff;
               newly_ff <= 1'b0;
               full_ff <= 1'b0;
               cnt_ff <= '0;
               ov_ff <= 1'b0;
               if (j_ff.cmd == prl_pkg::CMD_REG) begin
                  if (!rhit_ff) begin
                     cnt_ff <= 16'd1;
                     if (!rfree_ff) full_ff <= 1'b1;
                     else begin
                        rv_ff[rfi_ff] <= 1'b1;
                        rsrc_mem[rfi_ff] <= j_ff.source_addr;
                        rcnt_mem[rfi_ff] <= 16'd1;
                        rst_mem[rfi_ff] <= now_ff;
                     end
                  end else begin
                     rcnt_mem[rhi_ff] <= inc;
                     cnt_ff <= inc;
                     if (inc > request_limit) begin
                        ov_ff <= 1'b1;
                        rv_ff[rhi_ff] <= 1'b0;
                     end
                  end
               end
            end
            S_BUPD: if (ov_ff) begin
               if (bhit_ff || bfree_ff) begin
                  bv_ff[bhit_ff ? bhi_ff : bfi_ff] <= 1'b1;
                  bsrc_mem[bhit_ff ? bhi_ff : bfi_ff] <= j_ff.source_addr;
                  bun_mem[bhit_ff ? bhi_ff : bfi_ff] <= now_ff + {12'd0, block_ticks};
                  newly_ff <= 1'b1;
                  blkd_ff <= (block_ticks != 20'd0);
               end else begin
                  full_ff <= 1'b1;
               end
            end
            S_OUT: if (out_free) begin
               out_ff.is_blocked <= ((j_ff.cmd == prl_pkg::CMD_CHECK) ||
                                     (j_ff.cmd == prl_pkg::CMD_REG)) && blkd_ff;
               out_ff.newly_blocked <= newly_ff;
               out_ff.size_ok <= (j_ff.cmd == prl_pkg::CMD_SIZE) && j_ff.size_ok;
               out_ff.table_full <= full_ff;
               out_ff.request_count <= cnt_ff;
            end
            default: ;
         endcase
      end
   end
endmodule
